/* rtl/assert_macros.svh */
// Assertion macros shared by the block allocator RTL.
// No dependencies; compiled out when ASSERT_OFF is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define BBA_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);
// Expression must never be true outside reset.
`define BBA_NEVER(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(expr)) else $error(msg);
`else
`define BBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BBA_NEVER(lbl, clk, rstn, expr, msg)
`endif
`endif

/* rtl/bba_pkg.sv */
// Package for the block bitmap allocator: constants, status codes.
// No dependencies.
package bba_pkg;

    localparam int WORD_BITS      = 32;  // map bits per memory word
    localparam int WORD_IDX_W     = 5;   // log2(WORD_BITS)
    localparam int LANE_BITS      = 8;   // lane width inside the zero finder
    localparam int MAX_BLOCKS_DEF = 4096;
    localparam int RESULT_LIMIT   = 4096;
    localparam int BLK_W          = 12;
    localparam int CNT_W          = 13;
    localparam logic [CNT_W-1:0] TOTAL_RST = 13'd4096;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_FULL        = 2'd1,
        ST_DOUBLE_FREE = 2'd2,
        ST_RANGE       = 2'd3
    } t_status;

endpackage

/* rtl/block_bitmap_allocator.sv */
// Block bitmap allocator, top level: sequencer, map and summary memories.
// Depends on bba_pkg, bba_ram, bba_ffz and assert_macros.svh.
//
// - s_axis beat: tuser = mode (0 allocate, 1 free), tdata[11:0] = block to free.
//   Each beat gives one m_axis beat: tdata[11:0] = block allocated/freed (0 on
//   failure), tdata[13:12] = status (0 ok, 1 out of blocks, 2 freeing a free
//   block, 3 out of range).
// - i_cfg_we/i_cfg_wdata write total_blocks (reset 4096); write only when idle.
// - Used map sits in RAM as 32-bit words, a second RAM keeps one "word full"
//   bit per map word; one shared find-first-zero unit searches a summary word,
//   then the chosen map word.
// - A free out of range goes straight to the result; other frees read the map
//   and summary words and clear the block's bit and full mark (RMW); an allocate
//   scans summary words from the lowest, then reads and updates the chosen map word.
// - tready is high only while idle, so the next beat is taken only after the
//   last one has reached the output register: one item at a time.
// - A waiting result sits in the output register; the next item is taken
//   meanwhile and only its completion stalls on the receiver.
// - Reset: a clearing pass writes zero to every map word, one a cycle, with
//   tready low meanwhile.
module block_bitmap_allocator #(
    parameter int MAX_BLOCKS = bba_pkg::MAX_BLOCKS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // config
    input  logic                     i_cfg_we,
    input  logic [bba_pkg::CNT_W-1:0] i_cfg_wdata,   // total_blocks
    // request stream
    input  logic                     s_axis_tvalid,
    output logic                     s_axis_tready,
    input  logic [15:0]              s_axis_tdata,   // [11:0] block_number, [15:12] zero
    input  logic [0:0]               s_axis_tuser,   // [0] mode
    // result stream
    output logic                     m_axis_tvalid,
    input  logic                     m_axis_tready,
    output logic [15:0]              m_axis_tdata    // [11:0] block_number_res,
                                                     // [13:12] status, [15:14] zero
);
    `include "assert_macros.svh"

    localparam int WB   = bba_pkg::WORD_BITS;
    localparam int WI   = bba_pkg::WORD_IDX_W;
    localparam int DW   = (MAX_BLOCKS + WB - 1) / WB;      // map words
    localparam int SD   = (DW + WB - 1) / WB;              // summary words
    localparam int WAW  = (DW > 1) ? $clog2(DW) : 1;
    localparam int SAW  = (SD > 1) ? $clog2(SD) : 1;
    localparam int CW0  = (WAW + WI > bba_pkg::CNT_W) ? WAW + WI : bba_pkg::CNT_W;
    localparam int CW   = ((SAW + 2*WI > CW0) ? SAW + 2*WI : CW0) + 1;
    localparam int LIMIT = (MAX_BLOCKS < bba_pkg::RESULT_LIMIT) ? MAX_BLOCKS
                                                               : bba_pkg::RESULT_LIMIT;
    localparam int BW   = bba_pkg::BLK_W;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_FRD, S_FCHK, S_SRD, S_SCHK, S_DRD, S_DCHK, S_DONE
    } t_state;

    t_state                  r_state;
    logic [WAW-1:0]          r_clr_addr;
    logic [bba_pkg::CNT_W-1:0] r_total;
    logic [BW-1:0]           r_blk;
    logic [WAW-1:0]          r_waddr;
    logic [SAW-1:0]          r_saddr;
    logic [WB-1:0]           r_sum_word;
    logic [WI-1:0]           r_sbit;
    logic [BW-1:0]           r_res_blk;
    bba_pkg::t_status        r_res_st;
    logic                    r_out_valid;
    logic [BW-1:0]           r_out_blk;
    bba_pkg::t_status        r_out_st;

    logic [bba_pkg::CNT_W-1:0] eff;
    logic [CW-1:0]           eff_c;
    logic [WB-1:0]           dat_rdata, dat_wdata, sum_rdata, sum_wdata;
    logic                    dat_we, sum_we;
    logic [WAW-1:0]          dat_waddr;
    logic [SAW-1:0]          sum_waddr;
    logic [WB-1:0]           ffz_word;
    logic                    ffz_found;
    logic [WI-1:0]           ffz_idx;
    logic [WB-1:0]           dat_set;
    logic [CW-1:0]           w_base, next_sbase, blk_c;
    logic                    clr_last;

    // effective count: total_blocks saturated to MAX_BLOCKS and 4096
    assign eff   = (r_total > bba_pkg::CNT_W'(LIMIT)) ? bba_pkg::CNT_W'(LIMIT) : r_total;
    assign eff_c = CW'(eff);

    // shared search unit: summary word during the scan, map word after
    assign ffz_word = (r_state == S_DCHK) ? dat_rdata : sum_rdata;

    bba_ffz u_ffz (
        .i_word  (ffz_word),
        .o_found (ffz_found),
        .o_index (ffz_idx)
    );

    assign w_base     = CW'({r_saddr, ffz_idx}) << WI;        // first block of found word
    assign next_sbase = (CW'(r_saddr) + CW'(1)) << (2*WI);    // first block of next summary
    assign blk_c      = CW'({r_waddr, ffz_idx});
    assign dat_set    = dat_rdata | (WB'(1) << ffz_idx);
    assign clr_last   = (r_clr_addr == WAW'(DW - 1));

    // memory write side
    always_comb begin
        dat_we    = 1'b0;
        sum_we    = 1'b0;
        dat_waddr = r_waddr;
        sum_waddr = r_saddr;
        dat_wdata = dat_set;
        sum_wdata = r_sum_word | (WB'(1) << r_sbit);
        unique case (r_state)
            S_CLR: begin
                dat_we    = 1'b1;
                dat_waddr = r_clr_addr;
                dat_wdata = '0;
                sum_we    = (CW'(r_clr_addr) < CW'(SD));
                sum_waddr = SAW'(r_clr_addr);
                sum_wdata = '0;
            end
            S_FCHK: begin
                // freeing a used block also clears its word's full mark
                dat_we    = dat_rdata[r_blk[WI-1:0]];
                dat_wdata = dat_rdata & ~(WB'(1) << r_blk[WI-1:0]);
                sum_we    = dat_rdata[r_blk[WI-1:0]];
                sum_wdata = sum_rdata & ~(WB'(1) << r_blk[2*WI-1:WI]);
            end
            S_DCHK: begin
                dat_we = ffz_found && (blk_c < eff_c);
                sum_we = ffz_found && (blk_c < eff_c) && (&dat_set);
            end
            default: begin
            end
        endcase
    end

    bba_ram #(.WIDTH(WB), .DEPTH(DW)) u_map (
        .i_clk   (i_clk),
        .i_we    (dat_we),
        .i_waddr (dat_waddr),
        .i_wdata (dat_wdata),
        .i_raddr (r_waddr),
        .o_rdata (dat_rdata)
    );

    bba_ram #(.WIDTH(WB), .DEPTH(SD)) u_sum (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (r_saddr),
        .o_rdata (sum_rdata)
    );

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out_st, r_out_blk};

    // sequencer and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_total     <= bba_pkg::TOTAL_RST;
            r_out_valid <= 1'b0;
            r_saddr     <= '0;
            r_waddr     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            // S_DONE reloads the output register itself
            if (r_out_valid && m_axis_tready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_clr_addr <= r_clr_addr + WAW'(1);
                    if (clr_last) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        r_blk     <= s_axis_tdata[BW-1:0];
                        r_res_blk <= '0;
                        r_waddr   <= WAW'(s_axis_tdata[BW-1:0] >> WI);
                        if (!s_axis_tuser[0]) begin
                            r_saddr <= '0;
                            r_state <= S_SRD;
                        end else if (CW'(s_axis_tdata[BW-1:0]) >= eff_c) begin
                            r_res_st <= bba_pkg::ST_RANGE;
                            r_state  <= S_DONE;
                        end else begin
                            r_saddr <= SAW'(s_axis_tdata[BW-1:0] >> (2*WI));
                            r_state <= S_FRD;
                        end
                    end
                end
                S_FRD: begin
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    if (dat_rdata[r_blk[WI-1:0]]) begin
                        r_res_st  <= bba_pkg::ST_OK;
                        r_res_blk <= r_blk;
                    end else begin
                        r_res_st <= bba_pkg::ST_DOUBLE_FREE;
                    end
                    r_state <= S_DONE;
                end
                S_SRD: begin
                    r_state <= S_SCHK;
                end
                S_SCHK: begin
                    if (ffz_found) begin
                        if (w_base >= eff_c) begin
                            r_res_st <= bba_pkg::ST_FULL;
                            r_state  <= S_DONE;
                        end else begin
                            r_waddr    <= WAW'({r_saddr, ffz_idx});
                            r_sum_word <= sum_rdata;
                            r_sbit     <= ffz_idx;
                            r_state    <= S_DRD;
                        end
                    end else if ((r_saddr == SAW'(SD - 1)) || (next_sbase >= eff_c)) begin
                        r_res_st <= bba_pkg::ST_FULL;
                        r_state  <= S_DONE;
                    end else begin
                        r_saddr <= r_saddr + SAW'(1);
                        r_state <= S_SRD;
                    end
                end
                S_DRD: begin
                    r_state <= S_DCHK;
                end
                S_DCHK: begin
                    // lower words are full, so a zero at or above the count means none
                    if (ffz_found && (blk_c < eff_c)) begin
                        r_res_st  <= bba_pkg::ST_OK;
                        r_res_blk <= BW'(blk_c);
                    end else begin
                        r_res_st <= bba_pkg::ST_FULL;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_out_valid <= 1'b1;
                        r_out_blk   <= r_res_blk;
                        r_out_st    <= r_res_st;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `BBA_NEVER(a_no_accept_in_clear, i_clk, i_rst_n,
        (r_state == S_CLR) && s_axis_tready, "request taken during clearing pass")
    `BBA_ASSERT(a_fail_zero_block, i_clk, i_rst_n,
        (r_out_valid && (r_out_st != bba_pkg::ST_OK)) |-> (r_out_blk == '0),
        "failed result carries a nonzero block")
    `BBA_ASSERT(a_ok_below_count, i_clk, i_rst_n,
        (r_out_valid && (r_out_st == bba_pkg::ST_OK) && !i_cfg_we) |->
        (CW'(r_out_blk) < eff_c), "ok result names a block at or above the count")
    `BBA_ASSERT(a_sum_with_map, i_clk, i_rst_n,
        sum_we |-> (dat_we || (r_state == S_CLR)), "summary written without map word")
endmodule

/* rtl/bba_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

/* rtl/bba_ffz.sv */
// Find-first-zero unit: lowest clear bit of one map or summary word.
// Depends on bba_pkg.
module bba_ffz (
    input  logic [bba_pkg::WORD_BITS-1:0]  i_word,
    output logic                           o_found,
    output logic [bba_pkg::WORD_IDX_W-1:0] o_index
);
    localparam int NL = bba_pkg::WORD_BITS / bba_pkg::LANE_BITS;
    localparam int LW = $clog2(bba_pkg::LANE_BITS);

    logic [NL-1:0] lane_zero;
    logic [LW-1:0] lane_idx [NL];

    // per-lane search, lanes independent
    always_comb begin
        for (int l = 0; l < NL; l++) begin
            lane_zero[l] = ~&i_word[l*bba_pkg::LANE_BITS +: bba_pkg::LANE_BITS];
            lane_idx[l]  = '0;
            for (int k = bba_pkg::LANE_BITS - 1; k >= 0; k--) begin
                if (!i_word[l*bba_pkg::LANE_BITS + k]) begin
                    lane_idx[l] = LW'(k);
                end
            end
        end
    end

    // pick lowest lane holding a zero
    always_comb begin
        o_found = |lane_zero;
        o_index = '0;
        for (int l = NL - 1; l >= 0; l--) begin
            if (lane_zero[l]) begin
                o_index = bba_pkg::WORD_IDX_W'(l * bba_pkg::LANE_BITS + int'(lane_idx[l]));
            end
        end
    end
endmodule
